// File: rtl/srfr_pkg.sv
// package for the servo reply frame receiver
// holds item structs, controller/datapath interface structs and protocol codes
// no dependencies

package srfr_pkg;

    // default longest frame length field accepted
    localparam int MAX_PAYLOAD_LEN_DEF = 10;

    // frame constants
    localparam logic [7:0] HDR_BYTE = 8'h55;
    localparam logic [7:0] MIN_LEN  = 8'd3;

    // input opcodes
    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_HEADER   = 3'd2;
    localparam logic [2:0] ST_LENGTH   = 3'd3;
    localparam logic [2:0] ST_CHECKSUM = 3'd4;
    localparam logic [2:0] ST_ID       = 3'd5;
    localparam logic [2:0] ST_CMD      = 3'd6;

    // configuration register indexes
    localparam int          CFG_W             = 16;
    localparam logic [0:0]  CFG_TIMEOUT_TICKS = 1'd0;
    localparam logic [0:0]  CFG_BROADCAST_ID  = 1'd1;

    localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
    localparam logic [7:0]  BROADCAST_RESET = 8'd254;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
        logic [7:0] req_id;
        logic [7:0] req_cmd;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] servo_id;
        logic [7:0] command;
        logic [3:0] payload_length;
        logic [2:0] param_index;
        logic [7:0] param_byte;
        logic       param_valid;
        logic       last;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic       arm;
        logic       byte_seen;
        logic       tick;
        logic       take_id;
        logic       take_len;
        logic       take_body;
        logic       finish;
        logic [2:0] fin_status;
        logic       advance;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       hdr_match;
        logic       len_bad;
        logic       body_end;
        logic       tick_expire;
        logic [2:0] frame_status;
        logic       emit_last;
    } dp_stat_t;

endpackage

// File: rtl/srfr_datapath.sv
// datapath of the servo reply frame receiver: config, frame fields,
// checksum, parameter store, tick counter and result formatting
// depends on srfr_pkg

module srfr_datapath #(
    parameter int MAX_PAYLOAD_LEN = srfr_pkg::MAX_PAYLOAD_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [srfr_pkg::CFG_W-1:0]    cfg_data,
    input  srfr_pkg::item_t               item,
    input  srfr_pkg::ctrl_cmd_t           cmd,
    output srfr_pkg::dp_stat_t            stat,
    output srfr_pkg::result_t             result
);

    localparam int SLOTS = MAX_PAYLOAD_LEN - 3;
    localparam int LEN_W = $clog2(MAX_PAYLOAD_LEN + 1);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [7:0] MAX_LEN_B = 8'(MAX_PAYLOAD_LEN);

    logic [15:0]      timeout_reg;
    logic [7:0]       broadcast_reg;
    logic [15:0]      ticks_reg;
    logic [7:0]       want_id_reg;
    logic [7:0]       want_cmd_reg;
    logic [7:0]       got_id_reg;
    logic [LEN_W-1:0] got_len_reg;
    logic [7:0]       got_cmd_reg;
    logic [LEN_W-1:0] body_cnt_reg;
    logic [7:0]       sum_reg;
    logic [7:0]       store_reg [SLOTS];
    logic [2:0]       res_status_reg;
    logic             res_ok_reg;
    logic [CNT_W-1:0] emit_cnt_reg;

    logic [15:0]      ticks_inc;
    logic [LEN_W-1:0] nparams;
    logic [LEN_W-1:0] slot;
    logic             have_params;

    assign ticks_inc   = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
    assign nparams     = got_len_reg - LEN_W'(srfr_pkg::MIN_LEN);
    assign slot        = body_cnt_reg - LEN_W'(1);
    assign have_params = (nparams != '0);

    // status toward the controller
    always_comb
    begin
        stat.hdr_match   = (item.rx_byte == srfr_pkg::HDR_BYTE);
        stat.len_bad     = (item.rx_byte < srfr_pkg::MIN_LEN) || (item.rx_byte > MAX_LEN_B);
        stat.body_end    = ((body_cnt_reg + LEN_W'(2)) >= got_len_reg);
        stat.tick_expire = (ticks_inc >= timeout_reg);
        if (~sum_reg != item.rx_byte)
            stat.frame_status = srfr_pkg::ST_CHECKSUM;
        else if (want_id_reg != broadcast_reg && got_id_reg != want_id_reg)
            stat.frame_status = srfr_pkg::ST_ID;
        else if (got_cmd_reg != want_cmd_reg)
            stat.frame_status = srfr_pkg::ST_CMD;
        else
            stat.frame_status = srfr_pkg::ST_OK;
        stat.emit_last = !res_ok_reg || !have_params
                         || ((LEN_W'(emit_cnt_reg) + LEN_W'(1)) == nparams);
    end

    // result item
    always_comb
    begin
        result.status         = res_status_reg;
        result.servo_id       = got_id_reg;
        result.command        = got_cmd_reg;
        result.payload_length = res_ok_reg ? 4'(got_len_reg) : 4'd0;
        result.param_valid    = res_ok_reg && have_params;
        result.param_index    = result.param_valid ? 3'(emit_cnt_reg) : 3'd0;
        result.param_byte     = result.param_valid ? store_reg[emit_cnt_reg[IDX_W-1:0]]
                                                   : 8'd0;
        result.last           = stat.emit_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= srfr_pkg::TIMEOUT_RESET;
            broadcast_reg  <= srfr_pkg::BROADCAST_RESET;
            ticks_reg      <= '0;
            want_id_reg    <= '0;
            want_cmd_reg   <= '0;
            got_id_reg     <= '0;
            got_len_reg    <= '0;
            got_cmd_reg    <= '0;
            body_cnt_reg   <= '0;
            sum_reg        <= '0;
            res_status_reg <= srfr_pkg::ST_OK;
            res_ok_reg     <= 1'b0;
            emit_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == srfr_pkg::CFG_TIMEOUT_TICKS)
                    timeout_reg <= cfg_data;
                else
                    broadcast_reg <= cfg_data[7:0];
            end
            if (cmd.arm)
            begin
                want_id_reg  <= item.req_id;
                want_cmd_reg <= item.req_cmd;
                got_id_reg   <= '0;
                got_len_reg  <= '0;
                got_cmd_reg  <= '0;
                body_cnt_reg <= '0;
                sum_reg      <= '0;
                ticks_reg    <= '0;
            end
            if (cmd.byte_seen)
                ticks_reg <= '0;
            if (cmd.tick)
                ticks_reg <= ticks_inc;
            if (cmd.take_id)
            begin
                got_id_reg <= item.rx_byte;
                sum_reg    <= item.rx_byte;
            end
            if (cmd.take_len)
            begin
                got_len_reg  <= LEN_W'(item.rx_byte);
                sum_reg      <= sum_reg + item.rx_byte;
                body_cnt_reg <= '0;
            end
            if (cmd.take_body)
            begin
                if (body_cnt_reg == '0)
                    got_cmd_reg <= item.rx_byte;
                sum_reg      <= sum_reg + item.rx_byte;
                body_cnt_reg <= body_cnt_reg + LEN_W'(1);
            end
            if (cmd.finish)
            begin
                res_status_reg <= cmd.fin_status;
                res_ok_reg     <= (cmd.fin_status == srfr_pkg::ST_OK);
                emit_cnt_reg   <= '0;
            end
            if (cmd.advance)
                emit_cnt_reg <= emit_cnt_reg + CNT_W'(1);
        end
    end

    // parameter store, no reset: only written slots are read
    always_ff @(posedge clk)
    begin
        if (cmd.take_body && body_cnt_reg != '0 && slot < LEN_W'(SLOTS))
            store_reg[slot[IDX_W-1:0]] <= item.rx_byte;
    end

endmodule

// File: rtl/srfr_ctrl.sv
// controller of the servo reply frame receiver: frame phase and result sequencing
// depends on srfr_pkg

module srfr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [1:0]            opcode,
    output logic                  result_valid,
    input  logic                  result_ready,
    input  srfr_pkg::dp_stat_t    stat,
    output srfr_pkg::ctrl_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HDR1 = 3'd1;
    localparam logic [2:0] S_HDR2 = 3'd2;
    localparam logic [2:0] S_ID   = 3'd3;
    localparam logic [2:0] S_LEN  = 3'd4;
    localparam logic [2:0] S_BODY = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_ready   = (state_reg != S_EMIT);
    assign result_valid = (state_reg == S_EMIT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        if (state_reg == S_EMIT)
        begin
            if (result_ready)
            begin
                if (stat.emit_last)
                    state_next = S_IDLE;
                else
                    cmd.advance = 1'b1;
            end
        end
        else if (item_valid)
        begin
            unique case (opcode)
                srfr_pkg::OP_ARM:
                begin
                    cmd.arm    = 1'b1;
                    state_next = S_HDR1;
                end
                srfr_pkg::OP_BYTE:
                begin
                    if (state_reg != S_IDLE)
                    begin
                        cmd.byte_seen = 1'b1;
                        unique case (state_reg)
                            S_HDR1:
                            begin
                                if (stat.hdr_match)
                                    state_next = S_HDR2;
                            end
                            S_HDR2:
                            begin
                                if (stat.hdr_match)
                                    state_next = S_ID;
                                else
                                begin
                                    cmd.finish     = 1'b1;
                                    cmd.fin_status = srfr_pkg::ST_HEADER;
                                    state_next     = S_EMIT;
                                end
                            end
                            S_ID:
                            begin
                                cmd.take_id = 1'b1;
                                state_next  = S_LEN;
                            end
                            S_LEN:
                            begin
                                if (stat.len_bad)
                                begin
                                    cmd.finish     = 1'b1;
                                    cmd.fin_status = srfr_pkg::ST_LENGTH;
                                    state_next     = S_EMIT;
                                end
                                else
                                begin
                                    cmd.take_len = 1'b1;
                                    state_next   = S_BODY;
                                end
                            end
                            S_BODY:
                            begin
                                if (stat.body_end)
                                begin
                                    cmd.finish     = 1'b1;
                                    cmd.fin_status = stat.frame_status;
                                    state_next     = S_EMIT;
                                end
                                else
                                    cmd.take_body = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                srfr_pkg::OP_TICK:
                begin
                    if (state_reg != S_IDLE)
                    begin
                        cmd.tick = 1'b1;
                        if (stat.tick_expire)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = srfr_pkg::ST_TIMEOUT;
                            state_next     = S_EMIT;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/servo_reply_frame_receiver_core.sv
// top level of the servo reply frame receiver
// instantiates srfr_ctrl and srfr_datapath, depends on srfr_pkg

// An arm item latches the expected servo id and command and starts a hunt for
// a reply frame 0x55 0x55, id, length, command, parameters, checksum, fed one
// received byte per item; tick items drive the inter-byte timeout. Input
// items are taken back to back while item_ready is high. An item that ends
// the attempt (error, timeout or a complete frame) produces one result item,
// or one per parameter byte on a good frame with parameters (up to
// MAX_PAYLOAD_LEN-3), presented one per cycle while result_ready is high,
// from the parameter store; item_ready stays low from that point until the
// item marked last has been taken. Configuration writes go straight to the
// registers and are taken at any time.

module servo_reply_frame_receiver_core #(
    parameter int MAX_PAYLOAD_LEN = srfr_pkg::MAX_PAYLOAD_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input item channel
    input  logic                        item_valid,
    output logic                        item_ready,
    input  srfr_pkg::item_t             item,
    // result item channel
    output logic                        result_valid,
    input  logic                        result_ready,
    output srfr_pkg::result_t           result,
    // configuration write port
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [srfr_pkg::CFG_W-1:0]  cfg_data
);

    // command and status between controller and datapath
    srfr_pkg::ctrl_cmd_t cmd;
    srfr_pkg::dp_stat_t  stat;

    // controller owns the frame phase and the emit sequencing
    srfr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (item.opcode),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // datapath holds config, frame fields, checksum and the parameter store;
    // result fields come straight from its registers so they hold under stall
    srfr_datapath #(
        .MAX_PAYLOAD_LEN (MAX_PAYLOAD_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// testbench for servo_reply_frame_receiver_core: arm, byte and tick items in, reply items out
// expected replies come from a local frame parser model and are checked in order
// depends on srfr_pkg and the receiver rtl

module testbench;

    localparam int PARAM_SLOTS  = srfr_pkg::MAX_PAYLOAD_LEN_DEF - 3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 2 * PARAM_SLOTS + 2;

    // opcode three is not used by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [2:0] {RX_IDLE, RX_HUNT, RX_HDR2, RX_ID, RX_LEN, RX_BODY} rx_phase_t;

    // ways a random exchange departs from a clean reply
    typedef enum int {
        FL_NONE, FL_HEADER, FL_LENGTH, FL_CHECKSUM, FL_ID, FL_CMD, FL_TIMEOUT, FL_CUT, FL_NOISE
    } flaw_t;

    // block ports, every input known from time zero
    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    srfr_pkg::item_t   item         = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    srfr_pkg::result_t result;
    logic              cfg_we       = 1'b0;
    logic [0:0]        cfg_index    = '0;
    logic [srfr_pkg::CFG_W-1:0] cfg_data = '0;

    // frame parser model: registers and reception state
    logic [15:0] tmo_ticks  = srfr_pkg::TIMEOUT_RESET;
    logic [7:0]  bcast_id   = srfr_pkg::BROADCAST_RESET;
    rx_phase_t   rx_phase   = RX_IDLE;
    logic [15:0] tick_count = '0;
    logic [7:0]  want_id    = '0;
    logic [7:0]  want_cmd   = '0;
    logic [7:0]  got_id     = '0;
    logic [7:0]  got_len    = '0;
    logic [7:0]  got_cmd    = '0;
    logic [3:0]  bytes_left = '0;
    logic [7:0]  frame_sum  = '0;
    logic [7:0]  param_store [PARAM_SLOTS];

    // reply items still owed by the block, oldest first
    srfr_pkg::result_t replies_due [$];

    // frame under construction for the byte sender
    logic [7:0] frame_params [$];
    logic [7:0] frame_bytes [$];

    int error_count       = 0;
    int cycle_count       = 0;
    int active_items      = 0;
    int replies_predicted = 0;
    int send_gap_pct      = 0;
    int recv_stall_pct    = 0;
    int spread_pct        = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    servo_reply_frame_receiver_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ---------------------------------------------------------------------
    // frame parser model
    // ---------------------------------------------------------------------

    function automatic srfr_pkg::result_t reply(logic [2:0] st, logic [3:0] len,
                                                logic [2:0] idx, logic [7:0] pbyte,
                                                logic pvalid, logic fin);
        srfr_pkg::result_t r;
        r.status         = st;
        r.servo_id       = got_id;
        r.command        = got_cmd;
        r.payload_length = len;
        r.param_index    = idx;
        r.param_byte     = pbyte;
        r.param_valid    = pvalid;
        r.last           = fin;
        return r;
    endfunction

    function automatic void queue_reply(srfr_pkg::result_t r);
        replies_due.push_back(r);
        replies_predicted++;
    endfunction

    // every failure is a single item with the param fields cleared
    function automatic void end_with_error(logic [2:0] st);
        queue_reply(reply(st, 4'd0, 3'd0, 8'd0, 1'b0, 1'b1));
        rx_phase = RX_IDLE;
    endfunction

    // checksum first, then id (unless armed with the broadcast id), then command
    function automatic void end_of_frame(logic [7:0] check);
        int nparams;
        if (~frame_sum != check)
            end_with_error(srfr_pkg::ST_CHECKSUM);
        else if (want_id != bcast_id && got_id != want_id)
            end_with_error(srfr_pkg::ST_ID);
        else if (got_cmd != want_cmd)
            end_with_error(srfr_pkg::ST_CMD);
        else
        begin
            rx_phase = RX_IDLE;
            nparams  = int'(got_len) - int'(srfr_pkg::MIN_LEN);
            if (nparams == 0)
                queue_reply(reply(srfr_pkg::ST_OK, got_len[3:0], 3'd0, 8'd0, 1'b0, 1'b1));
            else
                for (int i = 0; i < nparams && i < PARAM_SLOTS; i++)
                    queue_reply(reply(srfr_pkg::ST_OK, got_len[3:0], 3'(i), param_store[i],
                                      1'b1, i + 1 == nparams));
        end
    endfunction

    function automatic void take_rx_byte(logic [7:0] b);
        int pos;
        tick_count = '0;
        case (rx_phase)
            // anything but the header byte is skipped while hunting
            RX_HUNT:
                if (b == srfr_pkg::HDR_BYTE)
                    rx_phase = RX_HDR2;
            RX_HDR2:
                if (b != srfr_pkg::HDR_BYTE)
                    end_with_error(srfr_pkg::ST_HEADER);
                else
                    rx_phase = RX_ID;
            RX_ID:
            begin
                got_id    = b;
                frame_sum = b;
                rx_phase  = RX_LEN;
            end
            RX_LEN:
                if (b < srfr_pkg::MIN_LEN || b > srfr_pkg::MAX_PAYLOAD_LEN_DEF)
                    end_with_error(srfr_pkg::ST_LENGTH);
                else
                begin
                    got_len    = b;
                    frame_sum  = frame_sum + b;
                    bytes_left = 4'(b - 8'd1);
                    rx_phase   = RX_BODY;
                end
            RX_BODY:
                if (bytes_left <= 1)
                    end_of_frame(b);
                else
                begin
                    pos = (int'(got_len) - 1) - int'(bytes_left);
                    if (pos == 0)
                        got_cmd = b;
                    else
                        param_store[pos - 1] = b;
                    frame_sum  = frame_sum + b;
                    bytes_left = bytes_left - 4'd1;
                end
            default: ;
        endcase
    endfunction

    // returns 1 when the block acts on the item, 0 when it just drops it
    function automatic bit step_frame_model(srfr_pkg::item_t it);
        case (it.opcode)
            srfr_pkg::OP_ARM:
            begin
                want_id    = it.req_id;
                want_cmd   = it.req_cmd;
                got_id     = '0;
                got_len    = '0;
                got_cmd    = '0;
                bytes_left = '0;
                frame_sum  = '0;
                tick_count = '0;
                rx_phase   = RX_HUNT;
                return 1'b1;
            end
            srfr_pkg::OP_BYTE:
            begin
                if (rx_phase == RX_IDLE)
                    return 1'b0;
                take_rx_byte(it.rx_byte);
                return 1'b1;
            end
            srfr_pkg::OP_TICK:
            begin
                if (rx_phase == RX_IDLE)
                    return 1'b0;
                if (tick_count != 16'hFFFF)
                    tick_count = tick_count + 16'd1;
                if (tick_count >= tmo_ticks)
                    end_with_error(srfr_pkg::ST_TIMEOUT);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // reply checking
    // ---------------------------------------------------------------------

    function automatic void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // sampled values are the ones before the edge, so the order of processes does not matter
    always @(posedge clk)
    begin : reply_check
        srfr_pkg::result_t want;
        if (result_valid && result_ready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected result item, expected none, actual %h", $time, result);
                error_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                compare_field("status", want.status, result.status);
                compare_field("servo_id", want.servo_id, result.servo_id);
                compare_field("command", want.command, result.command);
                compare_field("payload_length", want.payload_length, result.payload_length);
                compare_field("param_index", want.param_index, result.param_index);
                compare_field("param_byte", want.param_byte, result.param_byte);
                compare_field("param_valid", want.param_valid, result.param_valid);
                compare_field("last", want.last, result.last);
            end
        end
    end

    // receiver side back-pressure
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("servo_reply_frame_receiver_core verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // item senders
    // ---------------------------------------------------------------------

    // called at a rising edge; valid stays high straight into the next item
    // when no gap is drawn
    task automatic send_item(srfr_pkg::item_t it);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        if (step_frame_model(it))
            active_items++;
    endtask

    task automatic send_arm(logic [7:0] id, logic [7:0] cmd);
        srfr_pkg::item_t it;
        it         = '0;
        it.opcode  = srfr_pkg::OP_ARM;
        it.rx_byte = 8'($urandom);
        it.req_id  = id;
        it.req_cmd = cmd;
        send_item(it);
    endtask

    task automatic send_byte(logic [7:0] b);
        srfr_pkg::item_t it;
        it         = '0;
        it.opcode  = srfr_pkg::OP_BYTE;
        it.rx_byte = b;
        it.req_id  = 8'($urandom);
        it.req_cmd = 8'($urandom);
        send_item(it);
    endtask

    task automatic send_opcode(logic [1:0] op);
        srfr_pkg::item_t it;
        it         = '0;
        it.opcode  = op;
        it.rx_byte = 8'($urandom);
        it.req_id  = 8'($urandom);
        it.req_cmd = 8'($urandom);
        send_item(it);
    endtask

    // header, id, length, command, frame_params, checksum into frame_bytes
    function automatic void build_frame(logic [7:0] id, logic [7:0] len_field,
                                        logic [7:0] cmd, logic [7:0] ck_flip);
        logic [7:0] sum;
        sum = id + len_field + cmd;
        frame_bytes.delete();
        frame_bytes.push_back(srfr_pkg::HDR_BYTE);
        frame_bytes.push_back(srfr_pkg::HDR_BYTE);
        frame_bytes.push_back(id);
        frame_bytes.push_back(len_field);
        frame_bytes.push_back(cmd);
        foreach (frame_params[i])
        begin
            frame_bytes.push_back(frame_params[i]);
            sum = sum + frame_params[i];
        end
        frame_bytes.push_back(~sum ^ ck_flip);
    endfunction

    // first count bytes of the frame; ticks are spread in below the timeout
    task automatic send_frame_bytes(int count);
        int gap_ticks;
        for (int i = 0; i < count && i < frame_bytes.size(); i++)
        begin
            if ($urandom_range(99) < spread_pct)
            begin
                gap_ticks = $urandom_range(0, tmo_ticks > 4 ? 3 : int'(tmo_ticks) - 1);
                repeat (gap_ticks) send_opcode(srfr_pkg::OP_TICK);
            end
            if ($urandom_range(99) < spread_pct / 5)
                send_opcode(OP_UNUSED);
            send_byte(frame_bytes[i]);
        end
    endtask

    // drop valid, let every owed reply arrive and the block settle
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // both registers back to back, only while the block is idle
    task automatic write_config(logic [15:0] tmo, logic [7:0] bcast);
        cfg_we    <= 1'b1;
        cfg_index <= srfr_pkg::CFG_TIMEOUT_TICKS;
        cfg_data  <= tmo;
        @(posedge clk);
        cfg_index <= srfr_pkg::CFG_BROADCAST_ID;
        cfg_data  <= {{(srfr_pkg::CFG_W - 8){1'b0}}, bcast};
        @(posedge clk);
        cfg_we    <= 1'b0;
        tmo_ticks = tmo;
        bcast_id  = bcast;
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // nothing armed yet: byte, tick and the unused opcode all vanish
    task automatic test_ignored_while_idle();
        send_byte(srfr_pkg::HDR_BYTE);
        send_opcode(srfr_pkg::OP_TICK);
        send_item('1);
    endtask

    // longest frame with a junk byte ahead of the header, armed with the
    // broadcast id so the mismatching reply id is let through
    task automatic test_longest_frame();
        frame_params = '{8'hFF, 8'h00, 8'h55, 8'h80, 8'h7F, 8'h01, 8'hFE};
        build_frame(8'h00, 8'(srfr_pkg::MAX_PAYLOAD_LEN_DEF), 8'hFF, 8'h00);
        send_arm(srfr_pkg::BROADCAST_RESET, 8'hFF);
        send_byte(8'h00);
        send_frame_bytes(frame_bytes.size());
    endtask

    // second header byte wrong, then a length above the range
    task automatic test_header_and_length_errors();
        send_arm(8'hFF, 8'h00);
        send_byte(srfr_pkg::HDR_BYTE);
        send_byte(8'h54);
        send_arm(8'h01, 8'h02);
        send_byte(srfr_pkg::HDR_BYTE);
        send_byte(srfr_pkg::HDR_BYTE);
        send_byte(8'h01);
        send_byte(8'(srfr_pkg::MAX_PAYLOAD_LEN_DEF + 1));
    endtask

    // smallest timeout fires on the first tick; largest lets ticks pass,
    // and the attempt then ends on a length below the range
    task automatic test_timeout_extremes();
        wait_idle();
        write_config(16'd1, srfr_pkg::BROADCAST_RESET);
        send_arm(8'h10, 8'h20);
        send_opcode(srfr_pkg::OP_TICK);
        wait_idle();
        write_config(16'hFFFF, srfr_pkg::BROADCAST_RESET);
        send_arm(8'h7F, 8'h20);
        repeat (3) send_opcode(srfr_pkg::OP_TICK);
        send_byte(srfr_pkg::HDR_BYTE);
        send_byte(srfr_pkg::HDR_BYTE);
        send_byte(8'h7F);
        send_byte(8'h00);
    endtask

    // one arm plus reply, mostly well formed; clean forces a good reply
    task automatic run_exchange(bit clean);
        flaw_t           flaw;
        logic [7:0]      id, cmd, arm_id, arm_cmd, len_field, bad;
        logic [31:0]     raw;
        srfr_pkg::item_t noise;
        int              len, cut;
        if (clean || $urandom_range(99) < 40)
            flaw = FL_NONE;
        else
            flaw = flaw_t'($urandom_range(FL_HEADER, FL_NOISE));
        // a timeout at a huge limit would take far too many ticks
        if (flaw == FL_TIMEOUT && tmo_ticks > 64)
            flaw = FL_CUT;

        if (flaw == FL_NOISE)
        begin
            repeat ($urandom_range(2, 6))
            begin
                raw   = $urandom;
                noise = raw[$bits(srfr_pkg::item_t)-1:0];
                send_item(noise);
            end
            return;
        end

        id        = 8'($urandom);
        cmd       = 8'($urandom);
        len       = int'($urandom_range(srfr_pkg::MIN_LEN, srfr_pkg::MAX_PAYLOAD_LEN_DEF));
        len_field = 8'(len);
        arm_id    = ($urandom_range(3) == 0) ? bcast_id : id;
        arm_cmd   = cmd;
        case (flaw)
            FL_ID:
            begin
                arm_id = 8'($urandom);
                while (arm_id == id || arm_id == bcast_id)
                    arm_id = 8'($urandom);
            end
            FL_CMD: arm_cmd = cmd ^ 8'($urandom_range(1, 255));
            FL_LENGTH:
                if ($urandom_range(1) == 0)
                    len_field = 8'($urandom_range(0, srfr_pkg::MIN_LEN - 1));
                else
                    len_field = 8'($urandom_range(srfr_pkg::MAX_PAYLOAD_LEN_DEF + 1, 255));
            default: ;
        endcase

        frame_params.delete();
        repeat (len - srfr_pkg::MIN_LEN) frame_params.push_back(8'($urandom));
        build_frame(id, len_field, cmd,
                    (flaw == FL_CHECKSUM) ? 8'($urandom_range(1, 255)) : 8'h00);
        if (flaw == FL_HEADER)
        begin
            bad = 8'($urandom);
            if (bad == srfr_pkg::HDR_BYTE)
                bad = ~bad;
            frame_bytes[1] = bad;
        end
        // line noise ahead of the header is skipped by the hunt
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
            begin
                bad = 8'($urandom);
                if (bad == srfr_pkg::HDR_BYTE)
                    bad = ~bad;
                frame_bytes.push_front(bad);
            end

        send_arm(arm_id, arm_cmd);
        cut = frame_bytes.size();
        if (flaw == FL_TIMEOUT || flaw == FL_CUT)
            cut = $urandom_range(0, frame_bytes.size() - 1);
        send_frame_bytes(cut);
        if (flaw == FL_TIMEOUT)
            while (rx_phase != RX_IDLE)
                send_opcode(srfr_pkg::OP_TICK);
    endtask

    task automatic test_random_traffic(int gap_pct, int stall_pct,
                                       logic [15:0] tmo, logic [7:0] bcast);
        int items_goal, replies_goal;
        wait_idle();
        write_config(tmo, bcast);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        spread_pct     = 20;
        items_goal     = active_items + 50;
        replies_goal   = replies_predicted + 15;
        while (active_items < items_goal || replies_predicted < replies_goal)
            run_exchange(1'b0);
        // leave the block unarmed before the next register write
        while (rx_phase != RX_IDLE)
            run_exchange(1'b1);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct   = 38;
        recv_stall_pct = 68;
        test_ignored_while_idle();
        test_longest_frame();
        test_header_and_length_errors();
        test_timeout_extremes();

        test_random_traffic(38, 68, 16'd4, 8'h00);
        test_random_traffic(68, 38, 16'hFFFF, 8'hFF);
        test_random_traffic(0, 0, 16'd9, 8'($urandom));

        wait_idle();
        if (error_count == 0)
            $display("servo_reply_frame_receiver_core verification clean");
        else
            $display("servo_reply_frame_receiver_core verification failed");
        $finish;
    end

endmodule

// File: servo_reply_frame_receiver_core.f
rtl/srfr_pkg.sv
rtl/srfr_datapath.sv
rtl/srfr_ctrl.sv
rtl/servo_reply_frame_receiver_core.sv
bench/testbench.sv
